@@ sv/spvp_pkg.sv @@
package spvp_pkg;

	localparam int CMD_W       = 3;
	localparam int ADDR_W      = 13;
	localparam int BYTE_W      = 8;
	localparam int BIT_W       = 3;
	localparam int PEN_W       = 5;
	localparam int PLANES      = 6;
	localparam int FG_PLANES   = 3;
	localparam int PALETTE_N   = 7;
	localparam int WORD_W      = PLANES * BYTE_W;
	localparam int IN_DATA_W   = 24;
	localparam int OUT_DATA_W  = 40;
	// smallest plane is 2**8 bytes, so a 13-bit address holds at most 2**5 planes
	localparam int MIN_PLANE_LOG2 = 8;
	localparam int QUOT_BITS      = ADDR_W - MIN_PLANE_LOG2;

	localparam logic [BYTE_W-1:0] BAD_BANK_BYTE = 8'hff;
	localparam logic [PEN_W-1:0]  PEN_EMPTY     = 5'd16;
	localparam logic [BYTE_W-1:0] BANK_FIRST    = 8'd1;
	localparam logic [BYTE_W-1:0] BANK_LAST     = 8'd6;
	localparam logic [ADDR_W-1:0] PALETTE_LAST  = 13'd6;

	typedef enum logic [CMD_W-1:0] {
		CMD_READ       = 3'd0,
		CMD_WRITE      = 3'd1,
		CMD_BANK       = 3'd2,
		CMD_MASK       = 3'd3,
		CMD_PRIO       = 3'd4,
		CMD_PALETTE    = 3'd5,
		CMD_BACKGROUND = 3'd6,
		CMD_PIXEL      = 3'd7
	} cmd_t;

	typedef struct packed {
		logic [PLANES-1:0]                 prio;
		logic [PALETTE_N-1:0][BYTE_W-1:0]  palette;
		logic [BYTE_W-1:0]                 background;
	} video_regs_t;

endpackage

@@ sv/spvp_ram.sv @@
module spvp_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/spvp_pix.sv @@
module spvp_pix (
	input  logic [spvp_pkg::WORD_W-1:0] word,
	input  logic [spvp_pkg::BIT_W-1:0]  bit_index,
	input  spvp_pkg::video_regs_t       regs,
	output logic [spvp_pkg::PEN_W-1:0]  pen_index,
	output logic [spvp_pkg::BYTE_W-1:0] red,
	output logic [spvp_pkg::BYTE_W-1:0] green,
	output logic [spvp_pkg::BYTE_W-1:0] blue
);

	localparam logic [7:0] RED_MASK   = 8'h11;
	localparam logic [7:0] GREEN_MASK = 8'h22;
	localparam logic [7:0] BLUE_MASK  = 8'h44;
	localparam logic [7:0] RED_LO     = 8'h01;
	localparam logic [7:0] GREEN_LO   = 8'h02;
	localparam logic [7:0] BLUE_LO    = 8'h04;
	localparam logic [7:0] LEVEL_FULL = 8'hff;
	localparam logic [7:0] LEVEL_HALF = 8'h7f;

	function automatic logic [7:0] level(input logic [7:0] c, input logic [7:0] m,
		input logic [7:0] lo);
		logic [7:0] v;
		v = c & m;
		if (v == m) begin
			level = LEVEL_FULL;
		end else if (v == lo) begin
			level = LEVEL_HALF;
		end else begin
			level = 8'h00;
		end
	endfunction

	logic [spvp_pkg::FG_PLANES-1:0] fg, bg;
	logic [spvp_pkg::BYTE_W-1:0]    colour, mix;
	logic [2:0]                     base;

	always_comb begin
		for (int k = 0; k < spvp_pkg::FG_PLANES; k++) begin
			fg[k] = regs.prio[k] & word[spvp_pkg::BYTE_W*k + int'(bit_index)];
			bg[k] = regs.prio[k + spvp_pkg::FG_PLANES]
				& word[spvp_pkg::BYTE_W*(k + spvp_pkg::FG_PLANES) + int'(bit_index)];
		end
		priority if (fg != '0) begin
			pen_index = {2'b00, fg};
		end else if (bg != '0) begin
			pen_index = {2'b01, bg};
		end else begin
			pen_index = spvp_pkg::PEN_EMPTY;
		end
	end

	// background pens use palette bytes 3 to 5
	always_comb begin
		base = pen_index[3] ? 3'd3 : 3'd0;
		mix  = '0;
		for (int k = 0; k < spvp_pkg::FG_PLANES; k++) begin
			if (pen_index[k]) begin
				mix = mix | regs.palette[base + 3'(k)];
			end
		end
		if ((mix & regs.palette[spvp_pkg::PALETTE_N-1]) != '0) begin
			mix = mix & regs.palette[spvp_pkg::PALETTE_N-1];
		end
		colour = pen_index[4] ? regs.background : mix;
	end

	assign red   = level(colour, RED_MASK, RED_LO);
	assign green = level(colour, GREEN_MASK, GREEN_LO);
	assign blue  = level(colour, BLUE_MASK, BLUE_LO);

endmodule

@@ sv/six_plane_video_with_palette.sv @@
// a read or pixel word accepted into stage 1 is taken into the output register once stage 1 advances
// throughput: one word per cycle unless the output stalls; plane memory is read once per word, written back
// from stage 1, with the written row forwarded to a read of the same row
// reset: clears the valid, control and sweep registers, then sweeps the plane memory
// to zero one row a cycle; no input word is taken until the sweep is done
module six_plane_video_with_palette #(
	parameter int PLANE_BYTES = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // address[12:0], data[20:13], bit_index[23:21]
	input  logic [2:0]  s_axis_tuser,  // cmd[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // read_data[7:0], pen_index[12:8], red[20:13],
	                                   // green[28:21], blue[36:29], zero[39:37]
);

	localparam int AW = $clog2(PLANE_BYTES);
	localparam int AD = spvp_pkg::ADDR_W;
	localparam int BW = spvp_pkg::BYTE_W;
	localparam int WW = spvp_pkg::WORD_W;
	localparam logic [AW-1:0] LAST_ROW = AW'(PLANE_BYTES - 1);
	// reciprocal of the plane size, exact for any 13-bit address
	localparam int          RECIP_SHIFT = 26;
	localparam logic [31:0] RECIP       = 32'(((64'd1 << RECIP_SHIFT) + 64'(PLANE_BYTES)
		- 64'd1) / 64'(PLANE_BYTES));

	// input unpacking
	logic [AD-1:0]                 in_addr;
	logic [BW-1:0]                 in_data;
	logic [spvp_pkg::BIT_W-1:0]    in_bit;
	spvp_pkg::cmd_t                in_cmd;
	logic                          accept;
	logic [31:0]                   in_prod;
	logic [spvp_pkg::QUOT_BITS-1:0] in_quot;
	logic [AD-1:0]                 in_rem;
	logic [AW-1:0]                 in_idx;

	assign in_addr = s_axis_tdata[12:0];
	assign in_data = s_axis_tdata[20:13];
	assign in_bit  = s_axis_tdata[23:21];
	assign in_cmd  = spvp_pkg::cmd_t'(s_axis_tuser);
	assign accept  = s_axis_tvalid & s_axis_tready;

	// address modulo plane size: plane number by reciprocal multiply, then one subtract
	assign in_prod = 32'(in_addr) * RECIP;
	assign in_quot = in_prod[RECIP_SHIFT +: spvp_pkg::QUOT_BITS];
	assign in_rem  = in_addr - AD'(32'(in_quot) * 32'(PLANE_BYTES));
	assign in_idx  = AW'(in_rem);

	// clearing sweep
	logic          clr_q;
	logic [AW-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
			if (clr_cnt_q == LAST_ROW) begin
				clr_q <= 1'b0;
			end
		end
	end

	// stage 1: memory row available
	logic                       valid_s1;
	spvp_pkg::cmd_t             cmd_s1;
	logic [AD-1:0]              addr_s1;
	logic [AW-1:0]              idx_s1;
	logic [BW-1:0]              data_s1;
	logic [spvp_pkg::BIT_W-1:0] bit_s1;
	logic                       fwd_s1;
	logic [WW-1:0]              fwd_word_q;
	logic [WW-1:0]              ram_rdata;
	logic [WW-1:0]              word;
	logic [WW-1:0]              merged;
	logic                       has_result;
	logic                       adv;
	logic                       s1_write;

	// control registers
	logic [BW-1:0]                    read_bank_q;
	logic [spvp_pkg::PLANES-1:0]      write_mask_q;
	spvp_pkg::video_regs_t            regs_q;

	assign word       = fwd_s1 ? fwd_word_q : ram_rdata;
	assign has_result = (cmd_s1 == spvp_pkg::CMD_READ) || (cmd_s1 == spvp_pkg::CMD_PIXEL);
	assign adv        = !has_result || !m_axis_tvalid || m_axis_tready;
	assign s1_write   = valid_s1 && (cmd_s1 == spvp_pkg::CMD_WRITE);
	assign s_axis_tready = !clr_q && (!valid_s1 || adv);

	always_comb begin
		for (int k = 0; k < spvp_pkg::PLANES; k++) begin
			merged[BW*k +: BW] = write_mask_q[k] ? data_s1 : word[BW*k +: BW];
		end
	end

	spvp_ram #(
		.WIDTH (WW),
		.DEPTH (PLANE_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (clr_q | s1_write),
		.waddr (clr_q ? clr_cnt_q : idx_s1),
		.wdata (clr_q ? '0 : merged),
		.re    (accept),
		.raddr (in_idx),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= in_cmd;
			addr_s1    <= in_addr;
			idx_s1     <= in_idx;
			data_s1    <= in_data;
			bit_s1     <= in_bit;
			// the write in flight lands at this edge, after the read was taken
			fwd_s1     <= s1_write && (idx_s1 == in_idx);
			fwd_word_q <= merged;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_bank_q  <= '0;
			write_mask_q <= '0;
			regs_q       <= '0;
		end else if (valid_s1) begin
			unique case (cmd_s1)
				spvp_pkg::CMD_BANK:       read_bank_q <= data_s1;
				spvp_pkg::CMD_MASK:       write_mask_q <= data_s1[spvp_pkg::PLANES-1:0];
				spvp_pkg::CMD_PRIO:       regs_q.prio <= data_s1[spvp_pkg::PLANES-1:0];
				spvp_pkg::CMD_PALETTE: begin
					if (addr_s1 <= spvp_pkg::PALETTE_LAST) begin
						regs_q.palette[addr_s1[2:0]] <= data_s1;
					end
				end
				spvp_pkg::CMD_BACKGROUND: regs_q.background <= data_s1;
				spvp_pkg::CMD_READ,
				spvp_pkg::CMD_WRITE,
				spvp_pkg::CMD_PIXEL: ;
			endcase
		end
	end

	// bus read byte
	logic [BW-1:0] bank_byte;

	always_comb begin
		if (read_bank_q >= spvp_pkg::BANK_FIRST && read_bank_q <= spvp_pkg::BANK_LAST) begin
			bank_byte = word[BW*(read_bank_q[2:0] - 3'd1) +: BW];
		end else begin
			bank_byte = spvp_pkg::BAD_BANK_BYTE;
		end
	end

	logic [spvp_pkg::PEN_W-1:0] pen;
	logic [BW-1:0]              red, green, blue;

	spvp_pix u_pix (
		.word      (word),
		.bit_index (bit_s1),
		.regs      (regs_q),
		.pen_index (pen),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	// output register
	logic out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (valid_s1 && has_result && adv) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && has_result && adv) begin
			if (cmd_s1 == spvp_pkg::CMD_PIXEL) begin
				m_axis_tdata <= {3'b000, blue, green, red, pen, 8'h00};
			end else begin
				m_axis_tdata <= {32'h0, bank_byte};
			end
		end
	end

	assign m_axis_tvalid = out_v_q;

`ifndef SYNTHESIS
	a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !valid_s1)
		else $error("item in flight during memory clear");

	a_clear_runs_full_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_q) |-> $past(clr_cnt_q) == LAST_ROW)
		else $error("memory clear ended early");

	a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |-> (m_axis_tvalid && !m_axis_tready))
		else $error("stage 1 stalled without output back-pressure");

	a_stall_holds_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(cmd_s1) && $stable(idx_s1)))
		else $error("stalled word lost from stage 1");
`endif

endmodule
